// ===== rtl/keypad_lockout_long_press_macros.svh =====
// assertion macros shared by the keypad lockout long-press block
// expects clk and rst_n in the scope of each use
`ifndef KEYPAD_LOCKOUT_LONG_PRESS_MACROS_SVH
`define KEYPAD_LOCKOUT_LONG_PRESS_MACROS_SVH

// same-cycle implication, off during reset
`define KLL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad lockout: same-cycle check failed");

// next-cycle implication, off during reset
`define KLL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad lockout: next-cycle check failed");

`endif

// ===== rtl/kll_pkg.sv =====
// package for the keypad lockout long-press block
// types, register indexes and reset values; no dependencies
package kll_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned SEL_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 2'd1;

  // configuration reset values
  localparam logic [MS_W-1:0] LOCKOUT_RST = 16'd150;
  localparam logic [MS_W-1:0] HOLD_RST    = 16'd2000;

  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,
    KEY_ENTER = 2'd1,
    KEY_BACK  = 2'd2
  } key_code_t;

  typedef struct packed {
    logic [MS_W-1:0] lockout_ms;
    logic [MS_W-1:0] hold_ms;
  } cfg_t;

  // one poll item
  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic              down_level;
    logic              up_level;
    logic              enter_level;
    logic              back_level;
    logic              load_selection;
    logic [SEL_W-1:0]  load_value;
  } poll_t;

  // one result item
  typedef struct packed {
    key_code_t        key_code;
    logic [SEL_W-1:0] selection_value;
    logic             sleep_state;
    logic             enter_sleep;
    logic             leave_sleep;
  } result_t;

endpackage

// ===== rtl/kll_cfg_regs.sv =====
// configuration registers of the keypad lockout block
// uses kll_pkg for the register indexes and reset values
module kll_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [kll_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [kll_pkg::MS_W-1:0]      wr_data,
  output kll_pkg::cfg_t                 cfg
);

  logic [kll_pkg::MS_W-1:0] lockout_r, lockout_nxt;
  logic [kll_pkg::MS_W-1:0] hold_r, hold_nxt;

  // decode a write; unknown indexes are dropped
  always_comb begin
    lockout_nxt = lockout_r;
    hold_nxt    = hold_r;
    if (wr_en && (wr_index == kll_pkg::CFG_LOCKOUT)) begin
      lockout_nxt = wr_data;
    end
    if (wr_en && (wr_index == kll_pkg::CFG_HOLD)) begin
      hold_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r <= kll_pkg::LOCKOUT_RST;
      hold_r    <= kll_pkg::HOLD_RST;
    end else begin
      lockout_r <= lockout_nxt;
      hold_r    <= hold_nxt;
    end
  end

  assign cfg.lockout_ms = lockout_r;
  assign cfg.hold_ms    = hold_r;

endmodule

// ===== rtl/kll_poll_core.sv =====
// key handling state and per-poll update logic
// uses kll_pkg types and the shared assertion macros
`include "keypad_lockout_long_press_macros.svh"

module kll_poll_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  kll_pkg::cfg_t    cfg,
  input  kll_pkg::poll_t   item,
  output kll_pkg::result_t res
);

  logic [kll_pkg::TIME_W-1:0] last_accept_r, last_accept_nxt;
  logic                       back_prev_r, back_prev_nxt;
  logic [kll_pkg::TIME_W-1:0] press_start_r, press_start_nxt;
  logic [kll_pkg::TIME_W-1:0] hold_dur_r, hold_dur_nxt;
  logic                       toggled_r, toggled_nxt;
  logic                       sleep_r, sleep_nxt;
  logic [kll_pkg::SEL_W-1:0]  sel_r, sel_nxt;

  logic [kll_pkg::TIME_W-1:0] now;
  logic [kll_pkg::TIME_W-1:0] held_now;
  logic [kll_pkg::SEL_W-1:0]  sel_base;
  logic                       lock_ok;
  logic                       down_acc, up_acc, enter_acc, back_fall, back_acc;
  logic                       go_sleep, go_wake;

  assign now     = item.time_ms;
  assign lock_ok = (now - last_accept_r) > {{(kll_pkg::TIME_W-kll_pkg::MS_W){1'b0}},
                                            cfg.lockout_ms};

  // an accepted key moves the lockout start to now, blocking keys tried later
  assign down_acc  = !item.down_level && lock_ok;
  assign up_acc    = !item.up_level && lock_ok && !down_acc;
  assign enter_acc = !item.enter_level && lock_ok && !down_acc && !up_acc;
  assign back_fall = (item.back_level != back_prev_r) && !item.back_level;
  assign back_acc  = !enter_acc && back_fall && lock_ok && !down_acc && !up_acc;
  assign held_now  = now - press_start_r;

  // selection counter
  always_comb begin
    sel_base = item.load_selection ? item.load_value : sel_r;
    sel_nxt  = sel_base;
    if (down_acc) begin
      sel_nxt = sel_base + 1'b1;
    end else if (up_acc) begin
      sel_nxt = sel_base - 1'b1;
    end
  end

  // lockout restart, back key edge, hold timing and sleep toggle
  always_comb begin
    last_accept_nxt = last_accept_r;
    back_prev_nxt   = back_prev_r;
    press_start_nxt = press_start_r;
    hold_dur_nxt    = hold_dur_r;
    toggled_nxt     = toggled_r;
    sleep_nxt       = sleep_r;
    go_sleep        = 1'b0;
    go_wake         = 1'b0;
    if (down_acc || up_acc || enter_acc || back_acc) begin
      last_accept_nxt = now;
    end
    if (!enter_acc) begin
      back_prev_nxt = item.back_level;
      if (item.back_level != back_prev_r) begin
        if (!item.back_level) begin
          press_start_nxt = now;
          toggled_nxt     = 1'b0;
        end else begin
          hold_dur_nxt = held_now;
        end
      end else begin
        if (!item.back_level) begin
          hold_dur_nxt = held_now;
        end
        if ((hold_dur_nxt > {{(kll_pkg::TIME_W-kll_pkg::MS_W){1'b0}}, cfg.hold_ms})
            && !toggled_r) begin
          sleep_nxt   = !sleep_r;
          go_sleep    = !sleep_r;
          go_wake     = sleep_r;
          toggled_nxt = 1'b1;
        end
      end
    end
  end

  // result of this poll
  always_comb begin
    res.key_code        = enter_acc ? kll_pkg::KEY_ENTER :
                          (back_acc ? kll_pkg::KEY_BACK : kll_pkg::KEY_NONE);
    res.selection_value = sel_nxt;
    res.sleep_state     = sleep_nxt;
    res.enter_sleep     = go_sleep;
    res.leave_sleep     = go_wake;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_accept_r <= '0;
      back_prev_r   <= 1'b1;
      press_start_r <= '0;
      hold_dur_r    <= '0;
      toggled_r     <= 1'b0;
      sleep_r       <= 1'b0;
      sel_r         <= '0;
    end else if (step) begin
      last_accept_r <= last_accept_nxt;
      back_prev_r   <= back_prev_nxt;
      press_start_r <= press_start_nxt;
      hold_dur_r    <= hold_dur_nxt;
      toggled_r     <= toggled_nxt;
      sleep_r       <= sleep_nxt;
      sel_r         <= sel_nxt;
    end
  end

  // checks
  `KLL_ASSERT_NOW(a_sleep_on_flag, res.enter_sleep, res.sleep_state)
  `KLL_ASSERT_NOW(a_sleep_off_flag, res.leave_sleep, !res.sleep_state)
  `KLL_ASSERT_NOW(a_back_no_toggle, res.key_code == kll_pkg::KEY_BACK,
                  !res.enter_sleep && !res.leave_sleep)
  `KLL_ASSERT_NEXT(a_accept_restarts, step && (down_acc || enter_acc || back_acc),
                   last_accept_r == $past(now))

endmodule

// ===== rtl/keypad_lockout_long_press.sv =====
// top level of the keypad lockout long-press block
// uses kll_pkg, kll_cfg_regs and kll_poll_core
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | time, four key levels, selection load
//  out     | out_valid/ out_ready | key code, selection, sleep state and pulses
//  cfg     | cfg_valid/ cfg_ready | register index, 16-bit data
//
// one poll per cycle sustained while the output is not stalled; each poll passes through
// the input register, then the core update into the result register
// each core step does one subtract-and-compare for the lockout and one for the hold time
// synchronous reset restores lockout 150 ms, hold 2000 ms and resets all key state
// a stalled output holds the result register; input keeps flowing while one slot is free
// configuration writes are taken every cycle
module keypad_lockout_long_press (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kll_pkg::TIME_W-1:0]    in_time_ms,
  input  logic                          in_down_level,
  input  logic                          in_up_level,
  input  logic                          in_enter_level,
  input  logic                          in_back_level,
  input  logic                          in_load_selection,
  input  logic [kll_pkg::SEL_W-1:0]     in_load_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_key_code,
  output logic [kll_pkg::SEL_W-1:0]     out_selection_value,
  output logic                          out_sleep_state,
  output logic                          out_enter_sleep,
  output logic                          out_leave_sleep,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kll_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kll_pkg::MS_W-1:0]      cfg_data
);

  kll_pkg::cfg_t    cfg;
  kll_pkg::poll_t   in_item_r;
  kll_pkg::result_t core_res;
  kll_pkg::result_t out_item_r;
  logic             in_full_r, in_full_nxt;
  logic             out_full_r, out_full_nxt;
  logic             advance;
  logic             in_take;

  assign cfg_ready = 1'b1;

  kll_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // pipeline control
  assign advance      = in_full_r && (!out_full_r || out_ready);
  assign in_ready     = !in_full_r || advance;
  assign in_take      = in_valid && in_ready;
  assign in_full_nxt  = in_take || (in_full_r && !advance);
  assign out_full_nxt = advance || (out_full_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r  <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      in_full_r  <= in_full_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.time_ms        <= in_time_ms;
      in_item_r.down_level     <= in_down_level;
      in_item_r.up_level       <= in_up_level;
      in_item_r.enter_level    <= in_enter_level;
      in_item_r.back_level     <= in_back_level;
      in_item_r.load_selection <= in_load_selection;
      in_item_r.load_value     <= in_load_value;
    end
  end

  kll_poll_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .cfg   (cfg),
    .item  (in_item_r),
    .res   (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= core_res;
    end
  end

  assign out_valid           = out_full_r;
  assign out_key_code        = out_item_r.key_code;
  assign out_selection_value = out_item_r.selection_value;
  assign out_sleep_state     = out_item_r.sleep_state;
  assign out_enter_sleep     = out_item_r.enter_sleep;
  assign out_leave_sleep     = out_item_r.leave_sleep;

endmodule

// ===== tb/keypad_poll_checker.sv =====
// checker for the keypad lockout long-press block: watches the poll, result
// and register channels, predicts each result item and compares it field by field
// depends on kll_pkg for the item types, key codes and register indexes
module keypad_poll_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [kll_pkg::TIME_W-1:0]    in_time_ms,
  input  logic                          in_down_level,
  input  logic                          in_up_level,
  input  logic                          in_enter_level,
  input  logic                          in_back_level,
  input  logic                          in_load_selection,
  input  logic [kll_pkg::SEL_W-1:0]     in_load_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    out_key_code,
  input  logic [kll_pkg::SEL_W-1:0]     out_selection_value,
  input  logic                          out_sleep_state,
  input  logic                          out_enter_sleep,
  input  logic                          out_leave_sleep,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [kll_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kll_pkg::MS_W-1:0]      cfg_data,
  output int                            fail_count,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [kll_pkg::MS_W-1:0]   lock_window;
  logic [kll_pkg::MS_W-1:0]   hold_limit;

  // keypad state as the block should hold it
  logic [kll_pkg::TIME_W-1:0] last_key_time;
  logic                       back_was_level;
  logic [kll_pkg::TIME_W-1:0] back_down_time;
  logic [kll_pkg::TIME_W-1:0] back_held_for;
  logic                       toggled_this_press;
  logic                       asleep;
  logic [kll_pkg::SEL_W-1:0]  selection;

  kll_pkg::result_t           pending_results[$];
  int                         mismatches;

  // a key counts only once the lockout window has fully passed
  function automatic logic window_open(logic [kll_pkg::TIME_W-1:0] now);
    logic [kll_pkg::TIME_W-1:0] gap;
    gap = now - last_key_time;
    return gap > kll_pkg::TIME_W'(lock_window);
  endfunction

  // one poll: updates the keypad state and gives the result item it causes
  task automatic apply_poll(input kll_pkg::poll_t p, output kll_pkg::result_t r);
    kll_pkg::key_code_t key;
    logic               on_pulse;
    logic               off_pulse;
    key       = kll_pkg::KEY_NONE;
    on_pulse  = 1'b0;
    off_pulse = 1'b0;

    if (p.load_selection) selection = p.load_value;

    // down, up, enter in that order, each may close the window for the next
    if (!p.down_level && window_open(p.time_ms)) begin
      selection     = selection + 1'b1;
      last_key_time = p.time_ms;
    end
    if (!p.up_level && window_open(p.time_ms)) begin
      selection     = selection - 1'b1;
      last_key_time = p.time_ms;
    end
    if (!p.enter_level && window_open(p.time_ms)) begin
      key           = kll_pkg::KEY_ENTER;
      last_key_time = p.time_ms;
    end

    // back key only looked at when no enter went through
    if (key == kll_pkg::KEY_NONE) begin
      if (p.back_level != back_was_level) begin
        if (!p.back_level) begin
          back_down_time     = p.time_ms;
          toggled_this_press = 1'b0;
          if (window_open(p.time_ms)) begin
            key           = kll_pkg::KEY_BACK;
            last_key_time = p.time_ms;
          end
        end else begin
          back_held_for = p.time_ms - back_down_time;
        end
      end else begin
        if (!p.back_level) back_held_for = p.time_ms - back_down_time;
        // long hold flips sleep once per press, also after release
        if (back_held_for > kll_pkg::TIME_W'(hold_limit) && !toggled_this_press) begin
          if (!asleep) on_pulse = 1'b1;
          else off_pulse = 1'b1;
          asleep             = !asleep;
          toggled_this_press = 1'b1;
        end
      end
      back_was_level = p.back_level;
    end

    r.key_code        = key;
    r.selection_value = selection;
    r.sleep_state     = asleep;
    r.enter_sleep     = on_pulse;
    r.leave_sleep     = off_pulse;
  endtask

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    kll_pkg::poll_t   poll;
    kll_pkg::result_t want;
    if (!rst_n) begin
      lock_window        = kll_pkg::LOCKOUT_RST;
      hold_limit         = kll_pkg::HOLD_RST;
      last_key_time      = '0;
      back_was_level     = 1'b1;
      back_down_time     = '0;
      back_held_for      = '0;
      toggled_this_press = 1'b0;
      asleep             = 1'b0;
      selection          = '0;
      mismatches         = 0;
      pending_results.delete();
    end else begin
      // result side: compare with the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result item with no poll pending, expected none, actual key %0d",
                   $time, out_key_code);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("key_code", want.key_code, out_key_code);
          check_field("selection_value", want.selection_value, out_selection_value);
          check_field("sleep_state", want.sleep_state, out_sleep_state);
          check_field("enter_sleep", want.enter_sleep, out_enter_sleep);
          check_field("leave_sleep", want.leave_sleep, out_leave_sleep);
        end
      end

      // register writes, unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kll_pkg::CFG_LOCKOUT: lock_window = cfg_data;
          kll_pkg::CFG_HOLD:    hold_limit  = cfg_data;
          default: ;
        endcase
      end

      // poll side: predict and queue
      if (in_valid && in_ready) begin
        poll.time_ms        = in_time_ms;
        poll.down_level     = in_down_level;
        poll.up_level       = in_up_level;
        poll.enter_level    = in_enter_level;
        poll.back_level     = in_back_level;
        poll.load_selection = in_load_selection;
        poll.load_value     = in_load_value;
        apply_poll(poll, want);
        pending_results.push_back(want);
      end
    end
    fail_count  <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
// top of the keypad lockout long-press testbench: clock, reset, poll and
// register stimulus, result-side flow control, watchdog and verdict
// depends on kll_pkg, keypad_lockout_long_press and keypad_poll_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic PRESS = 1'b0;
  localparam logic FREE  = 1'b1;

  // indexes past the register file, writes there must be dropped
  localparam logic [kll_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [kll_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 2000;
  localparam int PHASE_POLLS     = 165;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [kll_pkg::TIME_W-1:0]    in_time_ms;
  logic                          in_down_level;
  logic                          in_up_level;
  logic                          in_enter_level;
  logic                          in_back_level;
  logic                          in_load_selection;
  logic [kll_pkg::SEL_W-1:0]     in_load_value;
  logic                          out_valid;
  logic                          out_ready;
  logic [1:0]                    out_key_code;
  logic [kll_pkg::SEL_W-1:0]     out_selection_value;
  logic                          out_sleep_state;
  logic                          out_enter_sleep;
  logic                          out_leave_sleep;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [kll_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kll_pkg::MS_W-1:0]      cfg_data;
  int                            fail_count;
  int                            outstanding;

  bit                            no_idling;
  bit                            ask_hold_off;
  int                            cur_lockout;
  int                            cur_hold;

  keypad_lockout_long_press i_dut (.*);

  keypad_poll_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (ask_hold_off) begin
        ask_hold_off = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= no_idling || ($urandom_range(0, 99) >= 26);
    end
  end

  // watchdog: too long without any item moving on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic kll_pkg::poll_t make_poll(logic [kll_pkg::TIME_W-1:0] t, logic d,
                                               logic u, logic e, logic b, logic ld,
                                               logic [kll_pkg::SEL_W-1:0] lv);
    kll_pkg::poll_t p;
    p.time_ms        = t;
    p.down_level     = d;
    p.up_level       = u;
    p.enter_level    = e;
    p.back_level     = b;
    p.load_selection = ld;
    p.load_value     = lv;
    return p;
  endfunction

  // offer one poll item, idling first at random, and wait for it to be taken
  task automatic offer_poll(input kll_pkg::poll_t p);
    while (!no_idling && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_time_ms        <= p.time_ms;
    in_down_level     <= p.down_level;
    in_up_level       <= p.up_level;
    in_enter_level    <= p.enter_level;
    in_back_level     <= p.back_level;
    in_load_selection <= p.load_selection;
    in_load_value     <= p.load_value;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait for every predicted result item
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kll_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kll_pkg::MS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // both registers, plus junk to the unused indexes
  task automatic program_limits(input int lockout, input int hold);
    write_reg(kll_pkg::CFG_LOCKOUT, kll_pkg::MS_W'(lockout));
    write_reg(kll_pkg::CFG_HOLD, kll_pkg::MS_W'(hold));
    write_reg(CFG_SPARE_A, kll_pkg::MS_W'($urandom()));
    write_reg(CFG_SPARE_B, kll_pkg::MS_W'($urandom()));
    cfg_valid   <= 1'b0;
    cur_lockout = lockout;
    cur_hold    = hold;
  endtask

  // random polls: time steps scaled to the lockout and hold windows,
  // back presses held over several polls, rare jumps anywhere in time
  task automatic run_polls(input int count);
    logic [kll_pkg::TIME_W-1:0] now;
    logic [kll_pkg::TIME_W-1:0] step;
    bit                         holding_back;
    int                         pick;
    kll_pkg::poll_t             p;
    now          = $urandom();
    holding_back = 1'b0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        step = $urandom_range(0, 2 * cur_lockout + 4);
      else if (pick < 92)
        step = $urandom_range(0, cur_hold + cur_hold / 2 + 4);
      else if (pick < 97)
        step = '0;
      else
        step = $urandom();
      now = now + step;
      if ($urandom_range(0, 99) < 20) holding_back = !holding_back;
      p.time_ms        = now;
      p.down_level     = ($urandom_range(0, 99) < 30) ? PRESS : FREE;
      p.up_level       = ($urandom_range(0, 99) < 30) ? PRESS : FREE;
      p.enter_level    = ($urandom_range(0, 99) < 20) ? PRESS : FREE;
      p.back_level     = holding_back ? PRESS : FREE;
      p.load_selection = ($urandom_range(0, 99) < 10);
      p.load_value     = $urandom_range(0, 255);
      offer_poll(p);
    end
  endtask

  initial begin : stimulus
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_time_ms        <= '0;
    in_down_level     <= FREE;
    in_up_level       <= FREE;
    in_enter_level    <= FREE;
    in_back_level     <= FREE;
    in_load_selection <= 1'b0;
    in_load_value     <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= kll_pkg::CFG_LOCKOUT;
    cfg_data          <= '0;
    no_idling   = 1'b0;
    ask_hold_off = 1'b0;
    cur_lockout = kll_pkg::LOCKOUT_RST;
    cur_hold    = kll_pkg::HOLD_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset limits: lockout 150, hold 2000
    offer_poll(make_poll(32'd0,    FREE,  FREE,  FREE,  FREE,  1'b0, 8'h00));
    offer_poll(make_poll(32'd100,  PRESS, FREE,  FREE,  FREE,  1'b0, 8'h00));
    offer_poll(make_poll(32'd151,  PRESS, FREE,  FREE,  FREE,  1'b0, 8'h00));
    // all three at once, only down gets through
    offer_poll(make_poll(32'd302,  PRESS, PRESS, PRESS, FREE,  1'b0, 8'h00));
    // selection wraps both ways after a load
    offer_poll(make_poll(32'd500,  PRESS, FREE,  FREE,  FREE,  1'b1, 8'hFF));
    offer_poll(make_poll(32'd700,  FREE,  PRESS, FREE,  FREE,  1'b1, 8'h00));
    // enter taken, back not looked at
    offer_poll(make_poll(32'd900,  FREE,  FREE,  PRESS, PRESS, 1'b0, 8'h55));
    // back press inside the lockout, then held into sleep
    offer_poll(make_poll(32'd910,  FREE,  FREE,  FREE,  PRESS, 1'b0, 8'h00));
    offer_poll(make_poll(32'd3000, FREE,  FREE,  FREE,  PRESS, 1'b0, 8'h00));
    offer_poll(make_poll(32'd3100, FREE,  FREE,  FREE,  PRESS, 1'b0, 8'h00));
    offer_poll(make_poll(32'd3200, FREE,  FREE,  FREE,  FREE,  1'b0, 8'h00));
    offer_poll(make_poll(32'd3300, FREE,  FREE,  FREE,  PRESS, 1'b0, 8'h00));
    offer_poll(make_poll(32'd3310, FREE,  FREE,  FREE,  FREE,  1'b0, 8'h00));
    // long press released before any held poll, wake comes after release
    offer_poll(make_poll(32'd3400, FREE,  FREE,  FREE,  PRESS, 1'b0, 8'h00));
    offer_poll(make_poll(32'd6000, FREE,  FREE,  FREE,  FREE,  1'b0, 8'h00));
    offer_poll(make_poll(32'd6010, FREE,  FREE,  FREE,  FREE,  1'b0, 8'h00));
    // time wraps through zero
    offer_poll(make_poll(32'hFFFF_FFF0, PRESS, FREE, FREE, FREE, 1'b0, 8'h00));
    offer_poll(make_poll(32'h0000_0010, PRESS, FREE, FREE, FREE, 1'b0, 8'h00));
    offer_poll(make_poll(32'h0000_00A0, PRESS, FREE, FREE, FREE, 1'b0, 8'h00));
    offer_poll(make_poll(32'hFFFF_FFFF, FREE,  FREE, PRESS, FREE, 1'b1, 8'hAA));
    drain_results();

    // zero lockout and zero hold
    program_limits(0, 0);
    offer_poll(make_poll(32'hFFFF_FFFF, PRESS, FREE, FREE, FREE, 1'b0, 8'h00));
    offer_poll(make_poll(32'd0,    PRESS, PRESS, PRESS, FREE,  1'b0, 8'h00));
    offer_poll(make_poll(32'd5,    FREE,  FREE,  FREE,  PRESS, 1'b0, 8'h00));
    offer_poll(make_poll(32'd5,    FREE,  FREE,  FREE,  PRESS, 1'b0, 8'h00));
    offer_poll(make_poll(32'd6,    FREE,  FREE,  FREE,  PRESS, 1'b0, 8'h00));
    drain_results();

    // random phases, one per register setting
    run_polls(PHASE_POLLS);
    drain_results();

    // widest windows, no idling, receiver holds off so the block backs up
    program_limits(65535, 65535);
    no_idling    = 1'b1;
    ask_hold_off = 1'b1;
    run_polls(PHASE_POLLS);
    drain_results();
    no_idling = 1'b0;

    program_limits(20, 300);
    run_polls(PHASE_POLLS);
    drain_results();

    program_limits($urandom_range(0, 200), $urandom_range(0, 2000));
    run_polls(PHASE_POLLS);
    drain_results();

    program_limits($urandom_range(0, 65535), $urandom_range(0, 65535));
    run_polls(PHASE_POLLS);
    drain_results();

    program_limits(kll_pkg::LOCKOUT_RST, kll_pkg::HOLD_RST);
    run_polls(PHASE_POLLS);
    drain_results();

    // let any stray result item show up
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
